@@ rtl/lzcd_pkg.sv @@
package lzcd_pkg;

  localparam int WIN_AW   = 12;
  localparam int MAX_SPAN = 64;
  localparam int SPAN_W   = 7;
  localparam int LIT_W    = 7;
  localparam int CFG_W    = 16;

  typedef logic [7:0]        byte_t;
  typedef logic [WIN_AW-1:0] win_addr_t;
  typedef logic [SPAN_W-1:0] span_t;
  typedef logic [LIT_W-1:0]  lit_cnt_t;
  typedef logic [CFG_W-1:0]  cfg_word_t;

  localparam logic REG_DLEN = 1'b0;
  localparam logic REG_SKIP = 1'b1;

  localparam logic [2:0] SPAN_CODE_MAX = 3'd7;
  localparam int         SPAN_BIAS     = 3;

  function automatic span_t span_of(input logic [2:0] code);
    span_of = (code == SPAN_CODE_MAX) ? span_t'(MAX_SPAN) : span_t'(code) + span_t'(SPAN_BIAS);
  endfunction

endpackage

@@ rtl/lzcd_ram.sv @@
module lzcd_ram #(
  parameter int DW    = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  assign rdata = rd_data_r;

endmodule

@@ rtl/lz_chunk_decompressor.sv @@
// LZ77 chunk decompressor with a 4096-byte history window held in one
// synchronous RAM. An input item is a compressed byte; a prefix byte or a pad
// byte gives no output, a literal or pass-through byte gives one output item.
// The second byte of a back-reference starts a copy of 3 to 9 bytes or of 64
// bytes: each copied byte is a window read followed by a write of the same
// byte at the output position, so overlapping copies see the bytes they just
// produced. Output goes through a one-item register; a stalled output holds
// the copy and input.
// Write decompressed_length (index 0) and skip_count (index 1) while idle.
module lz_chunk_decompressor
  import lzcd_pkg::*;
#(
  parameter int CHUNK_BYTES = 65536
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  byte_t in_byte,
  input  logic  in_start_chunk,
  output logic  out_valid,
  input  logic  out_ready,
  output byte_t out_byte,
  output logic [15:0] out_offset,
  output logic  out_run_last,
  output logic  out_chunk_done,
  output logic  out_overrun,
  input  logic  cfg_we,
  input  logic  cfg_index,
  input  cfg_word_t cfg_wdata
);

  localparam int POS_W = $clog2(CHUNK_BYTES) + 1;
  localparam int CMP_W = CFG_W + 1;
  localparam logic [POS_W-1:0] CHUNK_END  = POS_W'(CHUNK_BYTES);
  localparam logic [POS_W-1:0] CHUNK_LAST = POS_W'(CHUNK_BYTES - 1);

  localparam logic [1:0] S_IN  = 2'd0;
  localparam logic [1:0] S_CRD = 2'd1;
  localparam logic [1:0] S_CWR = 2'd2;

  localparam logic [1:0] PH_PFX  = 2'd0;
  localparam logic [1:0] PH_LIT  = 2'd1;
  localparam logic [1:0] PH_REF  = 2'd2;
  localparam logic [1:0] PH_TAIL = 2'd3;

  logic [1:0]       st_r, st_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  byte_t            held_r, held_nxt;
  lit_cnt_t         lit_r, lit_nxt;
  cfg_word_t        skip_r, skip_nxt;
  win_addr_t        dist_r, dist_nxt;
  span_t            cnt_r, cnt_nxt;
  cfg_word_t        dlen_r, skipcnt_r;

  logic             out_valid_r;
  byte_t            out_byte_r;
  logic [15:0]      out_offset_r;
  logic             out_last_r, out_done_r, out_ov_r;

  logic             in_acc, out_free, out_load;
  logic [POS_W-1:0] pos_e, pos_emit;
  logic [1:0]       phase_e;
  lit_cnt_t         lit_e;
  cfg_word_t        skip_e;
  logic [CMP_W-1:0] stream_end, pos_cmp;
  byte_t            ld_byte;
  logic             ld_ov, ld_last, emit_in, emit_ok;

  logic             ram_we, ram_re;
  win_addr_t        ram_waddr, ram_raddr;
  byte_t            ram_rdata;

  lzcd_ram #(
    .DW    (8),
    .DEPTH (1 << WIN_AW)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ld_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (st_r == S_IN) && out_free;
  assign in_acc   = in_valid && in_ready;

  assign stream_end = (CMP_W'(dlen_r) < CMP_W'(CHUNK_BYTES)) ? CMP_W'(dlen_r)
                                                             : CMP_W'(CHUNK_BYTES);

  assign pos_e   = in_start_chunk ? '0 : pos_r;
  assign lit_e   = in_start_chunk ? '0 : lit_r;
  assign phase_e = in_start_chunk ? ((stream_end == '0) ? PH_TAIL : PH_PFX) : phase_r;
  assign skip_e  = in_start_chunk ? ((stream_end == '0) ? skipcnt_r : '0) : skip_r;

  assign pos_emit    = (st_r == S_CWR) ? pos_r : pos_e;
  assign pos_cmp     = CMP_W'(pos_emit);
  assign emit_ok     = pos_emit < CHUNK_END;
  assign ram_waddr   = win_addr_t'(pos_emit);
  assign ram_raddr   = win_addr_t'(pos_r) - dist_r;

  always_comb begin
    st_nxt    = st_r;
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    held_nxt  = held_r;
    lit_nxt   = lit_r;
    skip_nxt  = skip_r;
    dist_nxt  = dist_r;
    cnt_nxt   = cnt_r;
    out_load  = 1'b0;
    emit_in   = 1'b0;
    ld_byte   = in_byte;
    ld_ov     = 1'b0;
    ld_last   = 1'b1;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    unique case (st_r)
      S_IN: begin
        if (in_acc) begin
          phase_nxt = phase_e;
          pos_nxt   = pos_e;
          lit_nxt   = lit_e;
          skip_nxt  = skip_e;
          unique case (phase_e)
            PH_PFX: begin
              if (in_byte[7]) begin
                held_nxt  = in_byte;
                phase_nxt = PH_REF;
              end else if (in_byte != '0) begin
                lit_nxt   = in_byte[LIT_W-1:0];
                phase_nxt = PH_LIT;
              end
            end
            PH_LIT: begin
              emit_in = 1'b1;
              ld_ov   = pos_cmp >= CMP_W'(dlen_r);
              lit_nxt = lit_e - 1'b1;
              if (lit_nxt == '0) begin
                phase_nxt = PH_PFX;
              end
            end
            PH_REF: begin
              dist_nxt = {held_r[6:0], in_byte[7:3]};
              cnt_nxt  = span_of(in_byte[2:0]);
              st_nxt   = S_CRD;
            end
            PH_TAIL: begin
              if (skip_e != '0) begin
                skip_nxt = skip_e - 1'b1;
              end else begin
                emit_in = 1'b1;
              end
            end
            default: phase_nxt = PH_PFX;
          endcase
          if (emit_in && emit_ok) begin
            out_load = 1'b1;
            ram_we   = 1'b1;
            pos_nxt  = pos_e + 1'b1;
          end
          if (phase_nxt == PH_PFX && CMP_W'(pos_nxt) >= stream_end) begin
            phase_nxt = PH_TAIL;
            skip_nxt  = skipcnt_r;
          end
        end
      end
      S_CRD: begin
        ram_re = 1'b1;
        st_nxt = S_CWR;
      end
      S_CWR: begin
        ld_byte = ram_rdata;
        ld_ov   = pos_cmp >= CMP_W'(dlen_r);
        ld_last = (cnt_r == span_t'(1)) || (pos_r == CHUNK_LAST);
        if (out_free) begin
          out_load = 1'b1;
          ram_we   = 1'b1;
          pos_nxt  = pos_r + 1'b1;
          cnt_nxt  = cnt_r - 1'b1;
          if (ld_last) begin
            st_nxt = S_IN;
            if (CMP_W'(pos_nxt) >= stream_end) begin
              phase_nxt = PH_TAIL;
              skip_nxt  = skipcnt_r;
            end else begin
              phase_nxt = PH_PFX;
            end
          end else begin
            st_nxt = S_CRD;
          end
        end
      end
      default: st_nxt = S_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IN;
      phase_r     <= PH_PFX;
      pos_r       <= '0;
      held_r      <= '0;
      lit_r       <= '0;
      skip_r      <= '0;
      dist_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      dlen_r      <= '0;
      skipcnt_r   <= '0;
    end else begin
      st_r        <= st_nxt;
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      held_r      <= held_nxt;
      lit_r       <= lit_nxt;
      skip_r      <= skip_nxt;
      dist_r      <= dist_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_load || (out_valid_r && !out_ready);
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DLEN: dlen_r    <= cfg_wdata;
          REG_SKIP: skipcnt_r <= cfg_wdata;
          default:  dlen_r    <= dlen_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte_r   <= ld_byte;
      out_offset_r <= pos_cmp[15:0];
      out_last_r   <= ld_last;
      out_done_r   <= pos_emit == CHUNK_LAST;
      out_ov_r     <= ld_ov;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_offset     = out_offset_r;
  assign out_run_last   = out_last_r;
  assign out_chunk_done = out_done_r;
  assign out_overrun    = out_ov_r;

  a_copy_in_ref: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != S_IN |-> phase_r == PH_REF)
    else $error("copy running outside back-reference phase");

  a_write_with_item: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> out_load)
    else $error("history write without an output item");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= CHUNK_END)
    else $error("output position beyond chunk size");

  a_copy_room: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_CRD |-> pos_r < CHUNK_END)
    else $error("copy read with a full chunk");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

import lzcd_pkg::*;

localparam int CHUNK_SIZE  = 65536;
localparam int WINDOW_SIZE = 1 << WIN_AW;
localparam int QUIET_LIMIT = 4000;
localparam int LONG_HOLD   = 400;

typedef enum logic [1:0] {PH_PREFIX, PH_LITERAL, PH_REF2, PH_TAIL} lz_phase_t;
typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_t;

typedef struct {
  byte_t       data;
  logic [15:0] offset;
  logic        last;
  logic        done;
  logic        ovr;
} out_item_t;

class chunk_tracker;
  byte_t       window [WINDOW_SIZE];
  bit          written [WINDOW_SIZE];
  int unsigned pos = 0;
  lz_phase_t   ph = PH_PREFIX;
  byte_t       prefix = '0;
  lit_cnt_t    lit_left = '0;
  cfg_word_t   skip_left = '0;
  cfg_word_t   dlen = '0;
  cfg_word_t   skip_cnt = '0;
  out_item_t   owed_bytes [$];
  int          errors = 0;
  int          n_checked = 0;

  task report(string msg);
    errors++;
    if (errors <= 40) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  function void set_reg(logic idx, cfg_word_t v);
    if (idx == REG_DLEN) dlen = v;
    else skip_cnt = v;
  endfunction

  function void end_of_stream();
    int unsigned lim;
    lim = (dlen < CHUNK_SIZE) ? dlen : CHUNK_SIZE;
    if (ph == PH_PREFIX && pos >= lim) begin
      ph = PH_TAIL;
      skip_left = skip_cnt;
    end
  endfunction

  function void put(byte_t b, logic ovr);
    out_item_t e;
    if (pos >= CHUNK_SIZE) return;
    window[pos % WINDOW_SIZE] = b;
    written[pos % WINDOW_SIZE] = 1'b1;
    e.data = b;
    e.offset = 16'(pos);
    e.last = 1'b0;
    e.done = (pos == CHUNK_SIZE - 1);
    e.ovr = ovr;
    owed_bytes.push_back(e);
    pos++;
  endfunction

  // true when every byte the copy reads was written at some point or is produced earlier by the same copy
  function bit copy_is_safe(int unsigned from, int unsigned back, int unsigned span);
    for (int unsigned i = 0; i < span && from + i < CHUNK_SIZE; i++)
      if (!written[(from + i - back) % WINDOW_SIZE] && !(back != 0 && back <= i)) return 1'b0;
    return 1'b1;
  endfunction

  // distance for a copy starting at from that reads only written bytes or its own earlier bytes, or -1
  function int safe_dist(int unsigned from, int unsigned span);
    int unsigned back;
    for (int k = 0; k < 8; k++) begin
      back = $urandom_range(0, WINDOW_SIZE - 1);
      if (copy_is_safe(from, back, span)) return int'(back);
    end
    if (from != 0) return int'($urandom_range(1, (from < WINDOW_SIZE - 1) ? from : WINDOW_SIZE - 1));
    if (copy_is_safe(from, 0, span)) return 0;
    return -1;
  endfunction

  function void take_input(byte_t b, logic st);
    int unsigned span, back, n0;
    out_item_t   e;
    n0 = owed_bytes.size();
    if (st) begin
      pos = 0;
      ph = PH_PREFIX;
      prefix = '0;
      lit_left = '0;
      skip_left = '0;
      end_of_stream();
    end
    case (ph)
      PH_PREFIX: begin
        if (b[7]) begin
          prefix = b;
          ph = PH_REF2;
        end else if (b != 0) begin
          lit_left = b[6:0];
          ph = PH_LITERAL;
        end
      end
      PH_LITERAL: begin
        put(b, pos >= dlen);
        lit_left = lit_left - 1'b1;
        if (lit_left == 0) ph = PH_PREFIX;
      end
      PH_REF2: begin
        span = (b[2:0] == SPAN_CODE_MAX) ? MAX_SPAN : b[2:0] + SPAN_BIAS;
        back = {prefix[6:0], b[7:3]};
        for (int unsigned i = 0; i < span && pos < CHUNK_SIZE; i++)
          put(window[(pos - back) % WINDOW_SIZE], pos >= dlen);
        ph = PH_PREFIX;
      end
      default: begin
        if (skip_left != 0) skip_left = skip_left - 1'b1;
        else put(b, 1'b0);
      end
    endcase
    end_of_stream();
    if (owed_bytes.size() > n0) begin
      e = owed_bytes.pop_back();
      e.last = 1'b1;
      owed_bytes.push_back(e);
    end
  endfunction

  task match_output(out_item_t got);
    out_item_t want;
    if (owed_bytes.size() == 0) begin
      report($sformatf("unexpected item: offset %0d byte %02h", got.offset, got.data));
      return;
    end
    want = owed_bytes.pop_front();
    n_checked++;
    if (got.data !== want.data)
      report($sformatf("offset %0d: byte %02h, want %02h", want.offset, got.data, want.data));
    if (got.offset !== want.offset)
      report($sformatf("offset %0d, want %0d", got.offset, want.offset));
    if (got.last !== want.last)
      report($sformatf("offset %0d: run_last %b, want %b", want.offset, got.last, want.last));
    if (got.done !== want.done)
      report($sformatf("offset %0d: chunk_done %b, want %b", want.offset, got.done, want.done));
    if (got.ovr !== want.ovr)
      report($sformatf("offset %0d: overrun %b, want %b", want.offset, got.ovr, want.ovr));
  endtask
endclass

module tb;
  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  byte_t       in_byte;
  logic        in_start_chunk;
  logic        out_valid;
  logic        out_ready;
  byte_t       out_byte;
  logic [15:0] out_offset;
  logic        out_run_last;
  logic        out_chunk_done;
  logic        out_overrun;
  logic        cfg_we;
  logic        cfg_index;
  cfg_word_t   cfg_wdata;

  chunk_tracker sb;
  int           burst_left = 0;
  int           n_sent = 0;
  int           n_settings = 0;
  int           quiet_cycles = 0;
  bit           hold_off_req = 1'b0;

  lz_chunk_decompressor #(.CHUNK_BYTES(CHUNK_SIZE)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_start_chunk (in_start_chunk),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_offset     (out_offset),
    .out_run_last   (out_run_last),
    .out_chunk_done (out_chunk_done),
    .out_overrun    (out_overrun),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic send_item(byte_t b, logic st);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_start_chunk <= st;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.take_input(b, st);
    n_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic write_regs(cfg_word_t dlen, cfg_word_t skip);
    cfg_we <= 1'b1;
    cfg_index <= REG_DLEN;
    cfg_wdata <= dlen;
    @(negedge clk);
    cfg_index <= REG_SKIP;
    cfg_wdata <= skip;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(REG_DLEN, dlen);
    sb.set_reg(REG_SKIP, skip);
    n_settings++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.owed_bytes.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic send_ref(int unsigned back, int unsigned code, logic st);
    send_item(byte_t'({1'b1, 7'(back >> 5)}), st);
    send_item(byte_t'({5'(back), 3'(code)}), 1'b0);
  endtask

  task automatic warm_up();
    send_item(8'h10, 1'b1);
    repeat (16) send_item(byte_t'($urandom), 1'b0);
    send_ref(1, SPAN_CODE_MAX, 1'b0);
    send_ref(16, SPAN_CODE_MAX, 1'b0);
    send_ref(70, SPAN_CODE_MAX, 1'b0);
    repeat (4) send_item(byte_t'($urandom), 1'b0);
  endtask

  task automatic random_traffic(int n_items);
    int          stop_at, len, pick;
    int unsigned code, span;
    logic        fresh, st;
    byte_t       b;
    stop_at = n_sent + n_items;
    while (n_sent < stop_at) begin
      fresh = (sb.ph == PH_TAIL) ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 24) == 0);
      if ($urandom_range(0, 11) == 0) begin
        st = ($urandom_range(0, 5) == 0);
        b = byte_t'($urandom);
        if (st || sb.ph == PH_PREFIX) b[7] = 1'b0;
        send_item(b, st);
      end else if (!fresh && sb.ph != PH_PREFIX) begin
        send_item(byte_t'($urandom), 1'b0);
      end else if ($urandom_range(0, 4) < 2) begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 127) : $urandom_range(1, 6);
        send_item(byte_t'(len), fresh);
        repeat (len) send_item(byte_t'($urandom), 1'b0);
      end else begin
        code = $urandom_range(0, 7);
        span = (code == SPAN_CODE_MAX) ? MAX_SPAN : code + SPAN_BIAS;
        pick = sb.safe_dist(fresh ? 0 : sb.pos, span);
        if (pick < 0) begin
          send_item(8'h01, fresh);
          send_item(byte_t'($urandom), 1'b0);
        end else begin
          send_ref(int'(pick), code, fresh);
        end
      end
    end
  endtask

  initial begin : stimulus
    sb = new;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte = '0;
    in_start_chunk = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_DLEN;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_regs(16'd208, 16'd2);
    warm_up();
    settle();

    write_regs(16'd4, 16'd2);
    send_item(8'h00, 1'b1);
    send_item(8'h03, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h5A, 1'b0);
    send_ref(1, 0, 1'b0);
    send_item(8'hAA, 1'b0);
    send_item(8'h55, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'h05, 1'b1);
    send_item(8'h11, 1'b0);
    send_item(8'h22, 1'b0);
    send_item(8'h33, 1'b0);
    send_item(8'h44, 1'b0);
    send_item(8'h7E, 1'b0);
    send_ref(0, 0, 1'b1);
    send_ref(WINDOW_SIZE - 1, SPAN_CODE_MAX, 1'b0);
    settle();

    write_regs(16'd0, 16'hFFFF);
    send_item(8'h9C, 1'b1);
    repeat (3) send_item(byte_t'($urandom), 1'b0);
    settle();

    write_regs(16'd0, 16'd0);
    send_item(8'h37, 1'b1);
    repeat (3) send_item(byte_t'($urandom), 1'b0);
    settle();

    hold_off_req = 1'b1;
    write_regs(cfg_word_t'($urandom_range(16, 64)), cfg_word_t'($urandom_range(0, 3)));
    random_traffic(20);
    settle();
    write_regs(cfg_word_t'($urandom_range(100, 600)), cfg_word_t'($urandom_range(0, 8)));
    random_traffic(20);
    settle();
    write_regs(cfg_word_t'($urandom_range(1, 16)), 16'd0);
    random_traffic(20);
    settle();

    $display("Run covered %0d compressed bytes and %0d decompressed bytes over %0d settings,",
             n_sent, sb.n_checked, n_settings);
    $display("with overlapping and far copies, pad skip, overrun, empty streams and tails.");
    if (sb.errors == 0 && sb.owed_bytes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : receiver
    rx_mode_t mode;
    int       mode_left, hold_left;
    byte_t    pattern;
    mode = RX_OPEN;
    mode_left = 0;
    hold_left = 0;
    pattern = 8'hFF;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = LONG_HOLD;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
          pattern = byte_t'($urandom_range(1, 255));
        end
        mode_left--;
        case (mode)
          RX_OPEN:    out_ready <= 1'b1;
          RX_COIN:    out_ready <= ($urandom_range(0, 1) == 1);
          RX_PATTERN: out_ready <= pattern[mode_left % 8];
          default:    out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    out_item_t got;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_byte, out_offset, out_run_last, out_chunk_done, out_overrun};
      sb.match_output(got);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end
endmodule
